FILE: design/iee_pkg.sv
// ============================================================================
// iee_pkg: shared constants for the infix expression evaluator
// Character codes, term operator codes and post-fold action codes.
// ============================================================================
`default_nettype none

package iee_pkg;

    // ASCII character codes
    localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_SPACE = 8'h20;  // ' ', ignored like any other code

    // Pending operator inside the open term
    typedef logic [1:0] t_op;
    localparam t_op OP_NONE = 2'd0;
    localparam t_op OP_MUL  = 2'd1;
    localparam t_op OP_DIV  = 2'd2;

    // What to do once the open number has been folded into the term
    typedef logic [1:0] t_post;
    localparam t_post POST_SETOP = 2'd0;  // latch the new '*' or '/'
    localparam t_post POST_TERM  = 2'd1;  // fold term into sum, latch sign
    localparam t_post POST_EMIT  = 2'd2;  // fold term, emit result, clear

endpackage : iee_pkg

`default_nettype wire

FILE: design/infix_expression_evaluator_core.sv
// ============================================================================
// infix_expression_evaluator_core: streaming infix integer evaluator
// Takes one ASCII character per transaction, applies '*' '/' before
// '+' '-', left to right, and returns the wrapped signed value on '='.
// ============================================================================
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-------------------------------
//  input   | in        | i_valid / o_ready    | i_char_code[7:0]
//  output  | out       | o_valid / i_ready    | o_value[31:0], o_div_zero_error
//
//  A digit is folded into the open number while the sequencer stays idle.
//  An operator folds that number into the term: directly when no '*' or
//  '/' is pending, by shift-add multiply after a '*', and after a '/' by
//  two magnitude steps, restoring divide and sign fix, all through one shared
//  adder/subtractor. '+', '-' and '=' use that adder in S_POST to fold the term.
//  o_ready is low while the sequencer is busy; a result waits in the output
//  register and only a '=' stalls when that register is still full.
//  Reset (i_rst_n low at a clock edge) clears the expression state and the
//  output valid flag.
//
`default_nettype none

module infix_expression_evaluator_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input character channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_char_code,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_value,
    output logic             o_div_zero_error
);

    import iee_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int AW = W + 2;            // shared adder width (divide needs W+1 plus sign)
    localparam int CW = $clog2(W);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ABSA = 3'd2;
    localparam logic [2:0] S_ABSB = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIX  = 3'd5;
    localparam logic [2:0] S_POST = 3'd6;

    // expression state
    logic [W-1:0]  r_sum;
    logic [W-1:0]  r_term;
    logic [W-1:0]  r_num;
    t_op           r_op;
    logic          r_neg;
    logic          r_err;

    // sequencer and shared-unit working registers
    logic [2:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_acc;     // product accumulator or division remainder
    logic [W-1:0]  r_a;       // multiplicand, or dividend shifting into quotient
    logic [W-1:0]  r_b;       // multiplier bits, or divisor
    logic          r_qneg;    // quotient takes a minus sign
    t_post         r_post;
    t_op           r_new_op;
    logic          r_new_neg;

    // output register
    logic          r_out_valid;
    logic [31:0]   r_value;
    logic          r_out_err;

    // shared adder/subtractor
    logic [AW-1:0] alu_x;
    logic [AW-1:0] alu_y;
    logic          alu_sub;
    logic [AW-1:0] alu_r;

    logic          is_digit;
    logic          cnt_done;
    logic          div_neg;
    logic [W-1:0]  num_next;
    logic          emit_go;

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_value          = r_value;
    assign o_div_zero_error = r_out_err;

    assign is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign cnt_done = (r_cnt == CW'(W - 1));
    // number times ten plus the new digit, wrapped to W bits
    assign num_next = (r_num << 3) + (r_num << 1) + W'(i_char_code - CH_ZERO);
    // load a result this cycle: terminator folded and output register free
    assign emit_go  = (r_state == S_POST) && (r_post == POST_EMIT) &&
                      (!r_out_valid || i_ready);

    // Select the operands of the one adder by sequencer step.
    always_comb begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                alu_x = {2'b00, r_acc};
                alu_y = r_b[0] ? {2'b00, r_a} : '0;
            end
            S_ABSA: begin
                alu_y   = {2'b00, r_a};
                alu_sub = r_a[W-1];
            end
            S_ABSB: begin
                alu_y   = {2'b00, r_b};
                alu_sub = r_b[W-1];
            end
            S_DIV: begin
                // trial subtract of divisor from remainder with next dividend bit
                alu_x   = {1'b0, r_acc, r_a[W-1]};
                alu_y   = {2'b00, r_b};
                alu_sub = 1'b1;
            end
            S_FIX: begin
                alu_y   = {2'b00, r_a};
                alu_sub = r_qneg;
            end
            S_POST: begin
                alu_x   = {2'b00, r_sum};
                alu_y   = {2'b00, r_term};
                alu_sub = r_neg;
            end
            default: begin
                alu_x   = '0;
            end
        endcase
        alu_r = alu_x + (alu_sub ? ~alu_y : alu_y) + AW'(alu_sub);
    end

    assign div_neg = alu_r[AW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_term      <= '0;
            r_num       <= '0;
            r_op        <= OP_NONE;
            r_neg       <= 1'b0;
            r_err       <= 1'b0;
            r_cnt       <= '0;
            r_qneg      <= 1'b0;
            r_post      <= POST_SETOP;
            r_new_op    <= OP_NONE;
            r_new_neg   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the result once the consumer takes it, unless a new one loads
            if (r_out_valid && i_ready && !emit_go) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (is_digit) begin
                            r_num <= num_next;
                        end else if (i_char_code == CH_STAR || i_char_code == CH_SLASH ||
                                     i_char_code == CH_PLUS || i_char_code == CH_MINUS ||
                                     i_char_code == CH_EQ) begin
                            // remember what follows the number fold
                            if (i_char_code == CH_STAR || i_char_code == CH_SLASH) begin
                                r_post <= POST_SETOP;
                            end else if (i_char_code == CH_EQ) begin
                                r_post <= POST_EMIT;
                            end else begin
                                r_post <= POST_TERM;
                            end
                            r_new_op  <= (i_char_code == CH_STAR) ? OP_MUL : OP_DIV;
                            r_new_neg <= (i_char_code == CH_MINUS);

                            // start folding the open number into the term
                            unique case (r_op)
                                OP_MUL: begin
                                    r_acc   <= '0;
                                    r_a     <= r_term;
                                    r_b     <= r_num;
                                    r_cnt   <= '0;
                                    r_state <= S_MUL;
                                end
                                OP_DIV: begin
                                    r_a     <= r_term;
                                    r_b     <= r_num;
                                    r_qneg  <= r_term[W-1] ^ r_num[W-1];
                                    r_state <= S_ABSA;
                                end
                                default: begin
                                    r_term  <= r_num;
                                    r_num   <= '0;
                                    r_state <= S_POST;
                                end
                            endcase
                        end
                    end
                end

                S_MUL: begin
                    r_acc <= alu_r[W-1:0];
                    r_a   <= r_a << 1;
                    r_b   <= r_b >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (cnt_done) begin
                        r_term  <= alu_r[W-1:0];
                        r_num   <= '0;
                        r_state <= S_POST;
                    end
                end

                S_ABSA: begin
                    r_a     <= alu_r[W-1:0];
                    r_state <= S_ABSB;
                end

                S_ABSB: begin
                    if (r_b == '0) begin
                        // divide by zero: quotient zero, flag the expression
                        r_err   <= 1'b1;
                        r_term  <= '0;
                        r_num   <= '0;
                        r_state <= S_POST;
                    end else begin
                        r_b     <= alu_r[W-1:0];
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    // restoring step: keep the difference when it stays non-negative
                    if (div_neg) begin
                        r_acc <= {r_acc[W-2:0], r_a[W-1]};
                    end else begin
                        r_acc <= alu_r[W-1:0];
                    end
                    r_a   <= {r_a[W-2:0], ~div_neg};
                    r_cnt <= r_cnt + 1'b1;
                    if (cnt_done) begin
                        r_state <= S_FIX;
                    end
                end

                S_FIX: begin
                    r_term  <= alu_r[W-1:0];
                    r_num   <= '0;
                    r_state <= S_POST;
                end

                S_POST: begin
                    unique case (r_post)
                        POST_SETOP: begin
                            r_op    <= r_new_op;
                            r_state <= S_IDLE;
                        end
                        POST_TERM: begin
                            r_sum   <= alu_r[W-1:0];
                            r_term  <= '0;
                            r_op    <= OP_NONE;
                            r_neg   <= r_new_neg;
                            r_state <= S_IDLE;
                        end
                        POST_EMIT: begin
                            // hold here until the output register is free
                            if (emit_go) begin
                                r_out_valid <= 1'b1;
                                r_value     <= 32'($signed(alu_r[W-1:0]));
                                r_out_err   <= r_err;
                                r_sum       <= '0;
                                r_term      <= '0;
                                r_num       <= '0;
                                r_op        <= OP_NONE;
                                r_neg       <= 1'b0;
                                r_err       <= 1'b0;
                                r_state     <= S_IDLE;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // the remainder always stays below the divisor during restoring steps
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_acc < r_b))
        else $error("division remainder reached the divisor");

    // the error flag rises only on a zero divisor check
    a_err_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_err) |-> ($past(r_state) == S_ABSB && $past(r_b) == '0))
        else $error("error flag set without a zero divisor");

    // a digit leaves the sequencer idle and the term untouched
    a_digit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && is_digit) |=> (r_state == S_IDLE && $stable(r_term)))
        else $error("digit disturbed sequencer or term");

    // a terminator always produces a result before the next character
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_POST && $past(r_post) == POST_EMIT && r_state == S_IDLE)
        |-> (r_out_valid && r_sum == '0 && r_err == 1'b0))
        else $error("terminator finished without emitting and clearing");

endmodule : infix_expression_evaluator_core

`default_nettype wire
